// File: hw/rtl/phg_pkg.sv
// Shared constants, types and the arctangent table for the polar hit to grid offset unit.
// No dependencies; every other file but phg_checker imports this package.
package phg_pkg;

  localparam int ANGLE_FRAC_BITS = 4;
  localparam int RANGE_BITS      = 16;
  localparam int UNIT_BITS       = 24;   // CORDIC angle unit is 2^-24 degree
  localparam int VEC_FRAC        = 30;   // CORDIC vectors are Q30
  localparam int VEC_W           = 33;
  localparam int Z_W             = 33;
  localparam int SUM_W           = 14;
  localparam int MAG_W           = RANGE_BITS + 2;
  localparam int DIV_W           = 14;
  localparam int PROD_W          = VEC_W + RANGE_BITS + 1;
  localparam int ATAN_LEN        = 24;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;

  localparam logic signed [SUM_W-1:0] ANG_FULL    = SUM_W'(360 << ANGLE_FRAC_BITS);
  localparam logic signed [SUM_W-1:0] ANG_HALF    = SUM_W'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [SUM_W-1:0] ANG_QUARTER = SUM_W'(90 << ANGLE_FRAC_BITS);

  localparam logic signed [VEC_W-1:0] CORDIC_X0 = VEC_W'(652032874);

  localparam logic [15:0]      MIN_RANGE_RESET = 16'd100;
  localparam logic [DIV_W-1:0] CELL_SIZE_RESET = DIV_W'(100);

  localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = CFG_IDX_W'(1);

  typedef struct packed {
    logic                  hit;
    logic                  neg_c;
    logic                  neg_y;
    logic [RANGE_BITS-1:0] range;
  } phg_tag_t;

  typedef struct packed {
    logic hit;
    logic sign_x;
    logic sign_y;
  } phg_sign_t;

  // atan(2^-i) in 2^-24 degree, rounded to nearest
  function automatic logic signed [31:0] atan_deg(input int unsigned i);
    logic signed [31:0] v;
    case (i)
      0:  v = 32'sd754974720;
      1:  v = 32'sd445687602;
      2:  v = 32'sd235489088;
      3:  v = 32'sd119537938;
      4:  v = 32'sd60000934;
      5:  v = 32'sd30029717;
      6:  v = 32'sd15018523;
      7:  v = 32'sd7509720;
      8:  v = 32'sd3754917;
      9:  v = 32'sd1877466;
      10: v = 32'sd938734;
      11: v = 32'sd469367;
      12: v = 32'sd234684;
      13: v = 32'sd117342;
      14: v = 32'sd58671;
      15: v = 32'sd29335;
      16: v = 32'sd14668;
      17: v = 32'sd7334;
      18: v = 32'sd3667;
      19: v = 32'sd1833;
      20: v = 32'sd917;
      21: v = 32'sd458;
      22: v = 32'sd229;
      23: v = 32'sd115;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/phg_if.sv
// Valid/ready channel interfaces: scanner return, grid offset result, register write.
// Depends on phg_pkg for widths.
interface phg_src_if;
  import phg_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [12:0]       beam_angle;
  logic        [15:0]       range_mm;
  logic signed [12:0]       heading;
  modport source (output valid, beam_angle, range_mm, heading, input ready);
  modport sink   (input valid, beam_angle, range_mm, heading, output ready);
endinterface

interface phg_dst_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [15:0] dx_cells;
  logic signed [15:0] dy_cells;
  modport source (output valid, hit, dx_cells, dy_cells, input ready);
  modport sink   (input valid, hit, dx_cells, dy_cells, output ready);
endinterface

interface phg_cfg_if;
  import phg_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/polar_hit_to_grid_offset_unit.sv
// Top level of the polar hit to grid offset unit: config registers, CORDIC,
// scaling multiply, divider and output stage. Depends on phg_pkg, phg_if and submodules.
//
// Usage:
//   src  - scanner returns (beam_angle, range_mm, heading), valid/ready.
//   dst  - one result per request (hit, dx_cells, dy_cells), valid/ready.
//   cfg  - register writes; index 0 is min_range_mm, index 1 cell_size_mm.
//          Always ready. Write only while no request is in flight.
// The pipeline is one prep stage, one stage per CORDIC micro-rotation,
// a multiply stage, a truncation stage, one stage per quotient bit of the
// 18-bit divider and the output register. Throughput is one request per
// cycle while dst does not stall; the whole pipeline moves as one shift line.
// When dst stalls with a result waiting, every stage holds and src.ready
// drops; only an empty or drained output register lets the line keep moving.
// Reset clears all stage valid bits and loads both registers with 100;
// no request is lost or repeated across a stall.
module polar_hit_to_grid_offset_unit import phg_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic  clk,
  input  logic  rst,
  phg_src_if.sink   src,
  phg_dst_if.source dst,
  phg_cfg_if.sink   cfg
);

  logic [15:0]      min_range;
  logic [DIV_W-1:0] cell_size;
  logic [DIV_W-1:0] divisor;
  logic             adv;

  // Advance every stage whenever the output register is free or drained.
  assign adv       = !dst.valid || dst.ready;
  assign src.ready = adv;
  assign cfg.ready = 1'b1;
  assign divisor   = (cell_size == '0) ? DIV_W'(1) : cell_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_range <= MIN_RANGE_RESET;
      cell_size <= CELL_SIZE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_MIN_RANGE: min_range <= cfg.data;
        REG_CELL_SIZE: cell_size <= cfg.data[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  // Angle prep
  logic                  p_valid;
  logic signed [Z_W-1:0] p_z;
  phg_tag_t              p_tag;

  phg_angle_prep u_prep (
    .clk, .rst, .en(adv),
    .in_valid(src.valid && src.ready),
    .beam_angle(src.beam_angle), .range_mm(src.range_mm), .heading(src.heading),
    .min_range(min_range),
    .out_valid(p_valid), .out_z(p_z), .out_tag(p_tag)
  );

  // CORDIC
  logic                    c_valid;
  logic signed [VEC_W-1:0] c_cos, c_sin;
  phg_tag_t                c_tag;

  phg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk, .rst, .en(adv),
    .in_valid(p_valid), .in_z(p_z), .in_tag(p_tag),
    .out_valid(c_valid), .out_cos(c_cos), .out_sin(c_sin), .out_tag(c_tag)
  );

  // Multiply by range; the cosine fold sign rides along and joins at truncation.
  logic signed [RANGE_BITS:0] rng_s;
  logic signed [PROD_W-1:0]   m_x, m_y;
  logic                       m_valid;
  phg_tag_t                   m_tag;

  assign rng_s = $signed({1'b0, c_tag.range});

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= c_valid;
    end
    if (adv) begin
      m_x   <= c_sin * rng_s;
      m_y   <= c_cos * rng_s;
      m_tag <= c_tag;
    end
  end

  // Truncate toward zero: take magnitudes, keep signs apart.
  logic [PROD_W-1:0] abs_x, abs_y;
  logic [MAG_W-1:0]  t_mag_x, t_mag_y;
  logic              t_valid;
  phg_sign_t         t_tag;

  assign abs_x = m_x[PROD_W-1] ? PROD_W'(-m_x) : PROD_W'(m_x);
  assign abs_y = m_y[PROD_W-1] ? PROD_W'(-m_y) : PROD_W'(m_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
    end else if (adv) begin
      t_valid <= m_valid;
    end
    if (adv) begin
      t_mag_x      <= abs_x[VEC_FRAC +: MAG_W];
      t_mag_y      <= abs_y[VEC_FRAC +: MAG_W];
      t_tag.hit    <= m_tag.hit;
      t_tag.sign_x <= m_x[PROD_W-1];
      t_tag.sign_y <= m_y[PROD_W-1] ^ m_tag.neg_c ^ m_tag.neg_y;
    end
  end

  // Divide by cell size
  logic             d_valid;
  logic [MAG_W-1:0] d_qx, d_qy;
  phg_sign_t        d_tag;

  phg_divider u_div (
    .clk, .rst, .en(adv), .divisor(divisor),
    .in_valid(t_valid), .in_num_x(t_mag_x), .in_num_y(t_mag_y), .in_tag(t_tag),
    .out_valid(d_valid), .out_quo_x(d_qx), .out_quo_y(d_qy), .out_tag(d_tag)
  );

  // Apply sign and saturate to 16-bit signed.
  function automatic logic signed [15:0] sat_cells(input logic [MAG_W-1:0] q, input logic neg);
    logic signed [15:0] v;
    if (!neg) begin
      v = (q > MAG_W'(32767)) ? 16'sh7fff : 16'(q);
    end else begin
      v = (q > MAG_W'(32768)) ? 16'sh8000 : 16'(-q);
    end
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      dst.valid <= 1'b0;
    end else if (adv) begin
      dst.valid <= d_valid;
    end
    if (adv) begin
      dst.hit      <= d_tag.hit;
      dst.dx_cells <= d_tag.hit ? sat_cells(d_qx, d_tag.sign_x) : '0;
      dst.dy_cells <= d_tag.hit ? sat_cells(d_qy, d_tag.sign_y) : '0;
    end
  end

endmodule

// File: hw/rtl/phg_angle_prep.sv
// Input stage: hit test, angle sum, reduction to (-180,180] and fold to [-90,90].
// Depends on phg_pkg.
module phg_angle_prep import phg_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [12:0]      beam_angle,
  input  logic        [15:0]      range_mm,
  input  logic signed [12:0]      heading,
  input  logic        [15:0]      min_range,
  output logic                    out_valid,
  output logic signed [Z_W-1:0]   out_z,
  output phg_tag_t                out_tag
);

  logic signed [SUM_W-1:0] sum, red, fold;
  logic                    neg_c;
  logic [RANGE_BITS-1:0]   rng;

  assign sum = SUM_W'(beam_angle) + SUM_W'(heading);
  assign rng = range_mm[RANGE_BITS-1:0];

  always_comb begin
    if (sum > ANG_HALF) begin
      red = sum - ANG_FULL;
    end else if (sum <= -ANG_HALF) begin
      red = sum + ANG_FULL;
    end else begin
      red = sum;
    end
    neg_c = 1'b0;
    if (red > ANG_QUARTER) begin
      fold  = ANG_HALF - red;
      neg_c = 1'b1;
    end else if (red < -ANG_QUARTER) begin
      fold  = -ANG_HALF - red;
      neg_c = 1'b1;
    end else begin
      fold = red;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_z         <= Z_W'(fold) <<< (UNIT_BITS - ANGLE_FRAC_BITS);
      out_tag.hit   <= 17'(rng) > 17'(min_range);
      out_tag.neg_c <= neg_c;
      out_tag.neg_y <= (sum >= -ANG_QUARTER && sum < SUM_W'(0)) || sum > ANG_QUARTER;
      out_tag.range <= rng;
    end
  end

endmodule

// File: hw/rtl/phg_cordic.sv
// Pipelined rotation-mode CORDIC, one micro-rotation per register stage.
// Depends on phg_pkg for vector widths and the arctangent table.
module phg_cordic import phg_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [Z_W-1:0]   in_z,
  input  phg_tag_t                in_tag,
  output logic                    out_valid,
  output logic signed [VEC_W-1:0] out_cos,
  output logic signed [VEC_W-1:0] out_sin,
  output phg_tag_t                out_tag
);

  logic                    vld [0:STEPS];
  logic signed [VEC_W-1:0] x   [0:STEPS];
  logic signed [VEC_W-1:0] y   [0:STEPS];
  logic signed [Z_W-1:0]   z   [0:STEPS];
  phg_tag_t                tag [0:STEPS];

  assign vld[0] = in_valid;
  assign x[0]   = CORDIC_X0;
  assign y[0]   = '0;
  assign z[0]   = in_z;
  assign tag[0] = in_tag;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [VEC_W-1:0] dx, dy;
    logic signed [Z_W-1:0]   ang;
    assign dx  = y[i] >>> i;
    assign dy  = x[i] >>> i;
    assign ang = Z_W'(atan_deg(i));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        tag[i+1] <= tag[i];
        if (!z[i][Z_W-1]) begin
          x[i+1] <= x[i] - dx;
          y[i+1] <= y[i] + dy;
          z[i+1] <= z[i] - ang;
        end else begin
          x[i+1] <= x[i] + dx;
          y[i+1] <= y[i] - dy;
          z[i+1] <= z[i] + ang;
        end
      end
    end
  end

  assign out_valid = vld[STEPS];
  assign out_cos   = x[STEPS];
  assign out_sin   = y[STEPS];
  assign out_tag   = tag[STEPS];

endmodule

// File: hw/rtl/phg_divider.sv
// Two-lane pipelined restoring divider, one quotient bit per stage, shared divisor.
// Depends on phg_pkg for widths and the sign tag.
module phg_divider import phg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic [DIV_W-1:0]   divisor,
  input  logic               in_valid,
  input  logic [MAG_W-1:0]   in_num_x,
  input  logic [MAG_W-1:0]   in_num_y,
  input  phg_sign_t          in_tag,
  output logic               out_valid,
  output logic [MAG_W-1:0]   out_quo_x,
  output logic [MAG_W-1:0]   out_quo_y,
  output phg_sign_t          out_tag
);

  logic             vld [0:MAG_W];
  phg_sign_t        tag [0:MAG_W];
  logic [MAG_W-1:0] num [0:1][0:MAG_W];
  logic [DIV_W-1:0] rem [0:1][0:MAG_W];

  assign vld[0]    = in_valid;
  assign tag[0]    = in_tag;
  assign num[0][0] = in_num_x;
  assign num[1][0] = in_num_y;
  assign rem[0][0] = '0;
  assign rem[1][0] = '0;

  for (genvar k = 0; k < MAG_W; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        tag[k+1] <= tag[k];
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DIV_W:0] trial;
      logic           take;
      assign trial = {rem[l][k], num[l][k][MAG_W-1]};
      assign take  = trial >= {1'b0, divisor};

      always_ff @(posedge clk) begin
        if (en) begin
          rem[l][k+1] <= take ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
          num[l][k+1] <= {num[l][k][MAG_W-2:0], take};
        end
      end
    end
  end

  assign out_valid = vld[MAG_W];
  assign out_tag   = tag[MAG_W];
  assign out_quo_x = num[0][MAG_W];
  assign out_quo_y = num[1][MAG_W];

endmodule

// File: hw/rtl/phg_checker.sv
// Port-level assertions for the polar hit to grid offset unit, bound to the top level.
// Depends on polar_hit_to_grid_offset_unit port names.
module phg_checker (
  input logic               clk,
  input logic               rst,
  input logic               src_ready,
  input logic               dst_valid,
  input logic               dst_ready,
  input logic               dst_hit,
  input logic signed [15:0] dst_dx,
  input logic signed [15:0] dst_dy
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !dst_valid)
    else $error("result valid right after reset");

  a_ready_follows_output: assert property (@(posedge clk) disable iff (rst)
    src_ready == (!dst_valid || dst_ready))
    else $error("request ready does not follow output drain");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    dst_valid && !dst_hit |-> dst_dx == 16'sd0 && dst_dy == 16'sd0)
    else $error("nonzero offset on a miss");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    dst_valid && !dst_ready |=> dst_valid && $stable(dst_dx) && $stable(dst_dy))
    else $error("stalled result changed");

endmodule

bind polar_hit_to_grid_offset_unit phg_checker u_phg_checker (
  .clk(clk), .rst(rst), .src_ready(src.ready),
  .dst_valid(dst.valid), .dst_ready(dst.ready), .dst_hit(dst.hit),
  .dst_dx(dst.dx_cells), .dst_dy(dst.dy_cells)
);

// File: bench/phg_scoreboard.sv
// Result checker for the polar hit to grid offset unit: predicts each grid offset
// from the accepted scanner returns and register writes. Depends on phg_pkg and phg_if.
module phg_scoreboard import phg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  phg_src_if        src,
  phg_dst_if        dst,
  phg_cfg_if        cfg,
  output int        fail_count,
  output int        pending
);

  typedef struct {
    logic               hit;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
  } offset_t;

  offset_t     offset_q[$];
  logic [15:0] min_range;
  logic [13:0] cell_size;

  function automatic longint shr_floor(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint trunc_vec(longint p);
    if (p >= 0) return p >>> VEC_FRAC;
    return -((-p) >>> VEC_FRAC);
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic offset_t grid_offset(logic signed [12:0] beam, logic [15:0] rng,
                                          logic signed [12:0] head);
    offset_t o;
    longint sum, r, full, half, quarter, x, y, z, ddx, ddy, dv, px, py;
    bit cneg;
    full = 360 << ANGLE_FRAC_BITS;
    half = 180 << ANGLE_FRAC_BITS;
    quarter = 90 << ANGLE_FRAC_BITS;
    cneg = 0;
    o.hit = 0; o.dx = 0; o.dy = 0;
    if (rng <= min_range) return o;
    sum = longint'(beam) + longint'(head);
    r = sum % full;
    if (r < 0) r += full;
    if (r > half) r -= full;
    if (r > quarter) begin
      r = half - r; cneg = 1;
    end else if (r < -quarter) begin
      r = -half - r; cneg = 1;
    end
    z = r * (longint'(1) << (UNIT_BITS - ANGLE_FRAC_BITS));
    x = 652032874; y = 0;
    for (int i = 0; i < 16; i++) begin
      ddx = shr_floor(y, i);
      ddy = shr_floor(x, i);
      if (z >= 0) begin
        x -= ddx; y += ddy; z -= longint'(atan_deg(i));
      end else begin
        x += ddx; y -= ddy; z += longint'(atan_deg(i));
      end
    end
    if (cneg) x = -x;
    dv = (cell_size != 0) ? longint'(cell_size) : 1;
    px = trunc_vec(y * longint'(rng)) / dv;
    py = trunc_vec(x * longint'(rng)) / dv;
    if ((sum >= -quarter && sum < 0) || sum > quarter) py = -py;
    o.hit = 1;
    o.dx = 16'(clamp16(px));
    o.dy = 16'(clamp16(py));
    return o;
  endfunction

  assign pending = offset_q.size();

  always @(posedge clk) begin
    offset_t want;
    if (rst) begin
      min_range <= MIN_RANGE_RESET;
      cell_size <= CELL_SIZE_RESET;
      offset_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_MIN_RANGE) min_range <= cfg.data;
        else if (cfg.index == REG_CELL_SIZE) cell_size <= cfg.data[13:0];
      end
      if (src.valid && src.ready)
        offset_q.push_back(grid_offset(src.beam_angle, src.range_mm, src.heading));
      if (dst.valid && dst.ready) begin
        if (offset_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result hit=%0b dx=%0d dy=%0d",
                                        dst.hit, dst.dx_cells, dst.dy_cells);
        end else begin
          want = offset_q.pop_front();
          if (dst.hit !== want.hit || dst.dx_cells !== want.dx ||
              dst.dy_cells !== want.dy) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: expected hit=%0b dx=%0d dy=%0d, got hit=%0b dx=%0d dy=%0d",
                       want.hit, want.dx, want.dy, dst.hit, dst.dx_cells, dst.dy_cells);
          end
        end
      end
    end
  end

endmodule

// File: bench/tb_polar_hit_to_grid_offset_unit.sv
// Stimulus and verdict for the polar hit to grid offset unit.
// Depends on phg_pkg, phg_if, the unit itself and phg_scoreboard.
module tb_polar_hit_to_grid_offset_unit;
  import phg_pkg::*;

  localparam int LATENCY     = 38;
  localparam int STALL_LIMIT = 4000;

  logic clk = 0;
  logic rst = 1;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  bit   calm;          // suppress random idling on both sides
  bit   hold_off;      // receiver long stall in progress
  bit   timed_out;

  phg_src_if src();
  phg_dst_if dst();
  phg_cfg_if cfg();

  polar_hit_to_grid_offset_unit dut (.clk(clk), .rst(rst), .src(src), .dst(dst), .cfg(cfg));
  phg_scoreboard checker_i (.clk(clk), .rst(rst), .src(src), .dst(dst), .cfg(cfg),
                            .fail_count(fail_count), .pending(pending));

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    src.valid = 0; src.beam_angle = 0; src.range_mm = 0; src.heading = 0;
    cfg.valid = 0; cfg.index = REG_MIN_RANGE; cfg.data = 0;
    dst.ready = 0;
    hold_off = 0; calm = 0;
  end

  // Receiver: randomly drop ready; honor a long hold-off when asked.
  always @(negedge clk) begin
    if (rst || hold_off) dst.ready <= 0;
    else dst.ready <= calm || ($urandom_range(99) >= 18);
  end

  // Watchdog: count cycles with no handshake anywhere.
  always @(posedge clk) begin
    if (rst || (src.valid && src.ready) || (dst.valid && dst.ready) ||
        (cfg.valid && cfg.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (!rst && idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Send one scanner return; random gaps before it unless calm.
  // Valid stays high after the handshake so requests can follow back to back.
  task automatic send_return(logic signed [12:0] beam, logic [15:0] rng,
                             logic signed [12:0] head);
    while (!calm && $urandom_range(99) < 18) begin
      src.valid <= 0;
      @(negedge clk);
    end
    src.valid <= 1;
    src.beam_angle <= beam;
    src.range_mm <= rng;
    src.heading <= head;
    do @(posedge clk); while (!src.ready);
    @(negedge clk);
  endtask

  // Write a register while nothing is in flight.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 0;
  endtask

  task automatic random_returns(int count);
    logic signed [12:0] beam, head;
    logic [15:0] rng;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: begin
          // any bit pattern, including out-of-range angles
          beam = 13'($urandom); head = 13'($urandom); rng = 16'($urandom);
        end
        1: begin
          // sums near multiples of 45 degrees, including the quadrant boundaries
          beam = 13'(int'($urandom_range(6)) * 720 - 2160 + int'($urandom_range(4)) - 2);
          head = 13'(int'($urandom_range(2)) - 1);
          rng = 16'($urandom);
        end
        default: begin
          beam = 13'(int'($urandom_range(5760)) - 2880);
          head = 13'(int'($urandom_range(5760)) - 2880);
          rng = 16'($urandom_range(65535));
        end
      endcase
      send_return(beam, rng, head);
    end
    src.valid <= 0;
  endtask

  // Long receiver stall while the sender keeps offering.
  initial begin
    wait (!rst);
    repeat (600) @(negedge clk);
    hold_off = 1;
    repeat (300) @(negedge clk);
    hold_off = 0;
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: field extremes, boundary sums, sign rule and no-hit cases.
    calm = 1;
    send_return(13'sd0, 16'd100, 13'sd0);         // range equal to minimum: no hit
    send_return(13'sd0, 16'd101, 13'sd0);
    send_return(13'sd1440, 16'd65535, 13'sd0);    // exactly 90 degrees
    send_return(-13'sd1440, 16'd65535, 13'sd0);   // exactly -90 degrees
    send_return(13'sd1441, 16'd5000, 13'sd0);
    send_return(-13'sd1, 16'd5000, 13'sd0);
    send_return(13'sd2880, 16'd65535, 13'sd2880); // sum 360
    send_return(-13'sd2880, 16'd65535, -13'sd2880);
    send_return(13'sd2880, 16'd3000, 13'sd0);     // 180
    send_return(-13'sd4096, 16'd65535, -13'sd4096);
    send_return(13'sd4095, 16'hFFFF, 13'sd4095);
    send_return(13'sd720, 16'd0, 13'sd720);
    src.valid <= 0;
    calm = 0;

    write_reg(REG_CELL_SIZE, 16'd1);              // saturation on large ranges
    write_reg(REG_MIN_RANGE, 16'd0);
    random_returns(400);
    write_reg(REG_CELL_SIZE, 16'd0);              // zero divides as one
    random_returns(150);
    write_reg(REG_CELL_SIZE, 16'h3FFF);
    write_reg(REG_MIN_RANGE, 16'hFFFF);           // nothing can hit
    random_returns(150);
    write_reg(REG_MIN_RANGE, 16'd30000);
    write_reg(REG_CELL_SIZE, 16'd10000);
    random_returns(300);
    write_reg(REG_MIN_RANGE, 16'd100);
    write_reg(REG_CELL_SIZE, 16'd7);
    calm = 1;
    random_returns(300);                          // no idling stretch
    calm = 0;
    write_reg(REG_CELL_SIZE, 16'd100);
    random_returns(600);

    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
